// ===== sv/scfp_pkg.sv =====
`timescale 1ns / 1ps

package scfp_pkg;

    localparam int BYTE_W  = 8;
    localparam int EVENT_W = 4;
    localparam int POS_W   = 12;
    localparam int PHASE_W = 3;

    localparam logic [PHASE_W-1:0] PH_SYNC  = 3'd0;
    localparam logic [PHASE_W-1:0] PH_CMD   = 3'd1;
    localparam logic [PHASE_W-1:0] PH_RELAY = 3'd2;
    localparam logic [PHASE_W-1:0] PH_PWM   = 3'd3;
    localparam logic [PHASE_W-1:0] PH_CLOCK = 3'd4;
    localparam logic [PHASE_W-1:0] PH_DATE  = 3'd5;
    localparam logic [PHASE_W-1:0] PH_FNAME = 3'd6;
    localparam logic [PHASE_W-1:0] PH_FDATA = 3'd7;

    localparam logic [EVENT_W-1:0] EV_RELAY     = 4'd0;
    localparam logic [EVENT_W-1:0] EV_PWM       = 4'd1;
    localparam logic [EVENT_W-1:0] EV_CLK_CH    = 4'd2;
    localparam logic [EVENT_W-1:0] EV_CLK_DONE  = 4'd3;
    localparam logic [EVENT_W-1:0] EV_DATE_CH   = 4'd4;
    localparam logic [EVENT_W-1:0] EV_DATE_DONE = 4'd5;
    localparam logic [EVENT_W-1:0] EV_NAME_CH   = 4'd6;
    localparam logic [EVENT_W-1:0] EV_NAME_DONE = 4'd7;
    localparam logic [EVENT_W-1:0] EV_FILE_BYTE = 4'd8;
    localparam logic [EVENT_W-1:0] EV_FILE_DONE = 4'd9;
    localparam logic [EVENT_W-1:0] EV_ERROR     = 4'd10;

    localparam logic [BYTE_W-1:0] CMD_RELAY = 8'd1;
    localparam logic [BYTE_W-1:0] CMD_PWM   = 8'd2;
    localparam logic [BYTE_W-1:0] CMD_CLOCK = 8'd3;
    localparam logic [BYTE_W-1:0] CMD_DATE  = 8'd4;
    localparam logic [BYTE_W-1:0] CMD_FILE  = 8'd5;

    localparam logic [BYTE_W-1:0] CH_SYNC  = 8'h21; // '!'
    localparam logic [BYTE_W-1:0] CH_SEP   = 8'h24; // '$'
    localparam logic [BYTE_W-1:0] CH_END   = 8'h23; // '#'
    localparam logic [BYTE_W-1:0] CH_COLON = 8'h3A; // ':'
    localparam logic [BYTE_W-1:0] CH_SLASH = 8'h2F; // '/'
    localparam logic [BYTE_W-1:0] CH_DOT   = 8'h2E; // '.'
    localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] CH_ONE   = 8'h31;
    localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;
    localparam logic [BYTE_W-1:0] CH_UA    = 8'h41;
    localparam logic [BYTE_W-1:0] CH_UF    = 8'h46;
    localparam logic [BYTE_W-1:0] CH_UZ    = 8'h5A;
    localparam logic [BYTE_W-1:0] CH_LA    = 8'h61;
    localparam logic [BYTE_W-1:0] CH_LZ    = 8'h7A;

    typedef struct packed {
        logic [POS_W-1:0]   position;
        logic [BYTE_W-1:0]  value;
        logic [EVENT_W-1:0] event_res;
    } t_result;

    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic [BYTE_W-1:0]  number_acc;
        logic               digits_ended;
    } t_parse;

    function automatic logic is_dec(input logic [BYTE_W-1:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_hex(input logic [BYTE_W-1:0] c);
        return is_dec(c) || ((c >= CH_UA) && (c <= CH_UF));
    endfunction

    function automatic logic is_alpha(input logic [BYTE_W-1:0] c);
        return ((c >= CH_LA) && (c <= CH_LZ)) || ((c >= CH_UA) && (c <= CH_UZ));
    endfunction

endpackage

// ===== sv/scfp_step.sv =====
`timescale 1ns / 1ps

module scfp_step #(
    parameter int TIME_CHARS = 8,
    parameter int NAME_CHARS = 29,
    parameter int FILE_BYTES = 2047,
    parameter int CNT_W      = 12
) (
    input  logic [scfp_pkg::BYTE_W-1:0] i_byte,
    input  scfp_pkg::t_parse            i_state,
    input  logic [CNT_W-1:0]            i_count,
    output scfp_pkg::t_parse            o_state,
    output logic [CNT_W-1:0]            o_count,
    output logic                        o_emit,
    output scfp_pkg::t_result           o_result
);

    localparam logic [CNT_W-1:0] TIME_CAP = CNT_W'(TIME_CHARS);
    localparam logic [CNT_W-1:0] NAME_CAP = CNT_W'(NAME_CHARS);
    localparam logic [CNT_W-1:0] FILE_CAP = CNT_W'(FILE_BYTES);

    logic [CNT_W+scfp_pkg::POS_W-1:0] w_count_ext;
    logic [scfp_pkg::POS_W-1:0]       w_pos;
    logic [scfp_pkg::BYTE_W-1:0]      w_acc_next;
    logic                             w_ended_next;
    logic [scfp_pkg::BYTE_W-1:0]      w_digit;
    logic                             w_is_clock;
    logic                             w_time_ok;
    logic [CNT_W-1:0]                 w_cap;
    logic                             w_room;

    assign w_count_ext = {{scfp_pkg::POS_W{1'b0}}, i_count};
    assign w_pos       = w_count_ext[scfp_pkg::POS_W-1:0];
    assign w_digit     = i_byte - scfp_pkg::CH_ZERO;
    assign w_is_clock  = (i_state.phase == scfp_pkg::PH_CLOCK);
    assign w_time_ok   = scfp_pkg::is_dec(i_byte) ||
                         (w_is_clock  && (i_byte == scfp_pkg::CH_COLON)) ||
                         (!w_is_clock && (i_byte == scfp_pkg::CH_SLASH));

    // atoi-style accumulate, stops at the first hex letter
    always_comb begin
        w_acc_next   = i_state.number_acc;
        w_ended_next = i_state.digits_ended;
        if (!i_state.digits_ended) begin
            if (scfp_pkg::is_dec(i_byte)) begin
                w_acc_next = (i_state.number_acc << 3) + (i_state.number_acc << 1) + w_digit;
            end else begin
                w_ended_next = 1'b1;
            end
        end
    end

    always_comb begin
        unique case (i_state.phase)
            scfp_pkg::PH_CLOCK, scfp_pkg::PH_DATE: w_cap = TIME_CAP;
            scfp_pkg::PH_FNAME:                    w_cap = NAME_CAP;
            default:                               w_cap = FILE_CAP;
        endcase
    end

    assign w_room = (i_count < w_cap);

    always_comb begin
        o_state            = i_state;
        o_count            = i_count;
        o_emit             = 1'b0;
        o_result.event_res = scfp_pkg::EV_ERROR;
        o_result.value     = '0;
        o_result.position  = '0;
        unique case (i_state.phase)
            scfp_pkg::PH_SYNC: begin
                if (i_byte == scfp_pkg::CH_SYNC) begin
                    o_state.phase        = scfp_pkg::PH_CMD;
                    o_state.number_acc   = '0;
                    o_state.digits_ended = 1'b0;
                    o_count              = '0;
                end
            end
            scfp_pkg::PH_CMD: begin
                if (scfp_pkg::is_hex(i_byte)) begin
                    o_state.number_acc   = w_acc_next;
                    o_state.digits_ended = w_ended_next;
                end else if (i_byte == scfp_pkg::CH_SEP) begin
                    o_state.number_acc   = '0;
                    o_state.digits_ended = 1'b0;
                    o_count              = '0;
                    unique case (i_state.number_acc)
                        scfp_pkg::CMD_RELAY: o_state.phase = scfp_pkg::PH_RELAY;
                        scfp_pkg::CMD_PWM:   o_state.phase = scfp_pkg::PH_PWM;
                        scfp_pkg::CMD_CLOCK: o_state.phase = scfp_pkg::PH_CLOCK;
                        scfp_pkg::CMD_DATE:  o_state.phase = scfp_pkg::PH_DATE;
                        scfp_pkg::CMD_FILE:  o_state.phase = scfp_pkg::PH_FNAME;
                        default:             o_state.phase = scfp_pkg::PH_SYNC;
                    endcase
                end
            end
            scfp_pkg::PH_RELAY: begin
                o_emit        = 1'b1;
                o_state.phase = scfp_pkg::PH_SYNC;
                if ((i_byte == scfp_pkg::CH_ZERO) || (i_byte == scfp_pkg::CH_ONE)) begin
                    o_result.event_res = scfp_pkg::EV_RELAY;
                    o_result.value     = w_digit;
                end
            end
            scfp_pkg::PH_PWM: begin
                if (scfp_pkg::is_hex(i_byte)) begin
                    o_state.number_acc   = w_acc_next;
                    o_state.digits_ended = w_ended_next;
                end else begin
                    o_emit        = 1'b1;
                    o_state.phase = scfp_pkg::PH_SYNC;
                    if (i_byte == scfp_pkg::CH_END) begin
                        o_result.event_res = scfp_pkg::EV_PWM;
                        o_result.value     = i_state.number_acc;
                    end
                end
            end
            scfp_pkg::PH_CLOCK, scfp_pkg::PH_DATE: begin
                if (w_time_ok) begin
                    o_emit             = w_room;
                    o_result.event_res = w_is_clock ? scfp_pkg::EV_CLK_CH
                                                    : scfp_pkg::EV_DATE_CH;
                    o_result.value     = i_byte;
                    o_result.position  = w_pos;
                    if (w_room) begin
                        o_count = i_count + 1'b1;
                    end
                end else begin
                    o_emit        = 1'b1;
                    o_state.phase = scfp_pkg::PH_SYNC;
                    if (i_byte == scfp_pkg::CH_END) begin
                        o_result.event_res = w_is_clock ? scfp_pkg::EV_CLK_DONE
                                                        : scfp_pkg::EV_DATE_DONE;
                        o_result.position  = w_pos;
                    end
                end
            end
            scfp_pkg::PH_FNAME: begin
                if (scfp_pkg::is_alpha(i_byte) || scfp_pkg::is_dec(i_byte) ||
                    (i_byte == scfp_pkg::CH_DOT)) begin
                    o_emit             = w_room;
                    o_result.event_res = scfp_pkg::EV_NAME_CH;
                    o_result.value     = i_byte;
                    o_result.position  = w_pos;
                    if (w_room) begin
                        o_count = i_count + 1'b1;
                    end
                end else if (i_byte == scfp_pkg::CH_SEP) begin
                    o_emit             = 1'b1;
                    o_state.phase      = scfp_pkg::PH_FDATA;
                    o_count            = '0;
                    o_result.event_res = scfp_pkg::EV_NAME_DONE;
                    o_result.position  = w_pos;
                end else begin
                    o_emit        = 1'b1;
                    o_state.phase = scfp_pkg::PH_SYNC;
                end
            end
            scfp_pkg::PH_FDATA: begin
                if (i_byte == scfp_pkg::CH_END) begin
                    o_emit             = 1'b1;
                    o_state.phase      = scfp_pkg::PH_SYNC;
                    o_result.event_res = scfp_pkg::EV_FILE_DONE;
                    o_result.position  = w_pos;
                end else begin
                    o_emit             = w_room;
                    o_result.event_res = scfp_pkg::EV_FILE_BYTE;
                    o_result.value     = i_byte;
                    o_result.position  = w_pos;
                    if (w_room) begin
                        o_count = i_count + 1'b1;
                    end
                end
            end
        endcase
    end

endmodule

// ===== sv/serial_command_frame_parser_core.sv =====
`timescale 1ns / 1ps
// Channel  | Dir | Handshake                     | Payload
// s_axis   | in  | s_axis_tvalid / s_axis_tready | rx_byte (8)
// m_axis   | out | m_axis_tvalid / m_axis_tready | event_res (4), value (8), position (12)
//
// Two stages: an input byte register, then one pass of parse logic into the result register.
// One byte per cycle sustained while the output is not stalled; each result is registered
// from its byte in the input register. Bytes producing no result still pass the parse stage.
// Synchronous active-low reset returns the parser to the sync search and empties both stages.
// A stalled output holds the parse stage; an empty input register still takes one more byte.

module serial_command_frame_parser_core #(
    parameter int TIME_CHARS = 8,
    parameter int NAME_CHARS = 29,
    parameter int FILE_BYTES = 2047
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // [3:0] event_res, [11:4] value, [23:12] position
);

    localparam int MAX_TN  = (TIME_CHARS > NAME_CHARS) ? TIME_CHARS : NAME_CHARS;
    localparam int MAX_CAP = (MAX_TN > FILE_BYTES) ? MAX_TN : FILE_BYTES;
    localparam int CNT_W   = $clog2(MAX_CAP + 1);

    logic                        r_in_valid;
    logic [scfp_pkg::BYTE_W-1:0] r_in_byte;
    scfp_pkg::t_parse            r_state;
    logic [CNT_W-1:0]            r_count;
    logic                        r_out_valid;
    scfp_pkg::t_result           r_out;

    scfp_pkg::t_parse            n_state;
    logic [CNT_W-1:0]            n_count;
    logic                        w_emit;
    scfp_pkg::t_result           w_result;
    logic                        w_advance;

    assign w_advance     = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_advance;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;

    scfp_step #(
        .TIME_CHARS (TIME_CHARS),
        .NAME_CHARS (NAME_CHARS),
        .FILE_BYTES (FILE_BYTES),
        .CNT_W      (CNT_W)
    ) u_step (
        .i_byte   (r_in_byte),
        .i_state  (r_state),
        .i_count  (r_count),
        .o_state  (n_state),
        .o_count  (n_count),
        .o_emit   (w_emit),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid           <= 1'b0;
            r_out_valid          <= 1'b0;
            r_state.phase        <= scfp_pkg::PH_SYNC;
            r_state.number_acc   <= '0;
            r_state.digits_ended <= 1'b0;
            r_count              <= '0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (w_advance) begin
                r_state     <= n_state;
                r_count     <= n_count;
                r_out_valid <= w_emit;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte <= s_axis_tdata;
        end
        if (w_advance && w_emit) begin
            r_out <= w_result;
        end
    end

    a_event_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.event_res <= scfp_pkg::EV_ERROR))
        else $error("event code out of range");

    a_relay_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.event_res == scfp_pkg::EV_RELAY)) |-> (r_out.value <= 8'd1))
        else $error("relay value not a single bit");

    a_time_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state.phase == scfp_pkg::PH_CLOCK) || (r_state.phase == scfp_pkg::PH_DATE))
        |-> (r_count <= CNT_W'(TIME_CHARS)))
        else $error("time count beyond capacity");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !m_axis_tready) |=> (r_out_valid && $stable(r_out)))
        else $error("result lost while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!r_out_valid && !r_in_valid))
        else $error("stages not empty after reset");

endmodule
